>>> rtl/smcs_pkg.sv
// Shared types and constants for the sound module command sequencer.
package smcs_pkg;

  localparam int unsigned TrackW  = 8;
  localparam int unsigned MsW     = 8;
  localparam int unsigned UsW     = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 8;

  localparam logic [MsW-1:0] MsMax = '1;

  typedef enum logic [1:0] {
    ModeMsTick = 2'd0,
    ModeUsTick = 2'd1,
    ModeSound  = 2'd2,
    ModeAlarm  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhReset  = 3'd1,
    PhSelect = 3'd2,
    PhSettle = 3'd3,
    PhShift  = 3'd4
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgResetLowMs   = 3'd0,
    CfgSelectHighMs = 3'd1,
    CfgSettleMs     = 3'd2,
    CfgBitLowUs     = 3'd3,
    CfgBitHighUs    = 3'd4,
    CfgSoundEnable  = 3'd5,
    CfgAlarmEnable  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [MsW-1:0] reset_low_ms;
    logic [MsW-1:0] select_high_ms;
    logic [MsW-1:0] settle_ms;
    logic [UsW-1:0] bit_low_us;
    logic [UsW-1:0] bit_high_us;
    logic           sound_enable;
    logic           alarm_enable;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    reset_low_ms:   8'd9,
    select_high_ms: 8'd20,
    settle_ms:      8'd10,
    bit_low_us:     6'd15,
    bit_high_us:    6'd22,
    sound_enable:   1'b1,
    alarm_enable:   1'b1
  };

  typedef struct packed {
    logic rst;
    logic sel;
    logic clk;
    logic dat;
  } pins_t;

  localparam pins_t PinsReset = '{rst: 1'b1, sel: 1'b1, clk: 1'b1, dat: 1'b0};

  typedef struct packed {
    pins_t pins;
    logic  busy;
  } result_t;

endpackage

>>> rtl/smcs_cmd_if.sv
// Command channel: tick and play request transactions.
interface smcs_cmd_if
  import smcs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [TrackW-1:0] track;

  modport source (output valid, mode, track, input ready);
  modport sink   (input valid, mode, track, output ready);
endinterface

>>> rtl/smcs_pin_if.sv
// Result channel: pin levels and busy flag after each command.
interface smcs_pin_if;
  logic valid;
  logic ready;
  logic reset_line;
  logic select_line;
  logic clock_line;
  logic data_line;
  logic busy_res;

  modport source (output valid, reset_line, select_line, clock_line, data_line, busy_res,
                  input ready);
  modport sink   (input valid, reset_line, select_line, clock_line, data_line, busy_res,
                  output ready);
endinterface

>>> rtl/smcs_cfg_if.sv
// Configuration write channel.
interface smcs_cfg_if
  import smcs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/smcs_core.sv
// Sequencer state and next-state logic for one command per step.
module smcs_core
  import smcs_pkg::*;
#(
  parameter int unsigned TRACK_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  mode_e             mode_i,
  input  logic [TrackW-1:0] track_i,
  input  cfg_t              cfg_i,
  output result_t           res_o
);

  localparam int unsigned CntW = (TRACK_BITS > 1) ? $clog2(TRACK_BITS) : 1;
  localparam logic [CntW:0] BitsTotal = TRACK_BITS[CntW:0];

  phase_e            phase_q, phase_d;
  logic [MsW-1:0]    elapsed_q, elapsed_d;
  logic [TrackW-1:0] shift_q, shift_d;
  logic [CntW-1:0]   bits_q, bits_d;
  logic [UsW-1:0]    timer_q, timer_d;
  logic              half_q, half_d;
  pins_t             pins_q, pins_d;

  logic [MsW-1:0]    el_inc;
  logic [UsW-1:0]    tm_inc;
  logic [CntW:0]     bits_inc;
  logic              req_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      elapsed_q <= '0;
      shift_q   <= '0;
      bits_q    <= '0;
      timer_q   <= '0;
      half_q    <= 1'b0;
      pins_q    <= PinsReset;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      shift_q   <= shift_d;
      bits_q    <= bits_d;
      timer_q   <= timer_d;
      half_q    <= half_d;
      pins_q    <= pins_d;
    end
  end

  assign el_inc   = (elapsed_q == MsMax) ? MsMax : elapsed_q + 1'b1;
  assign tm_inc   = timer_q + 1'b1;
  assign bits_inc = {1'b0, bits_q} + 1'b1;
  assign req_en   = (mode_i == ModeSound) ? cfg_i.sound_enable : cfg_i.alarm_enable;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    shift_d   = shift_q;
    bits_d    = bits_q;
    timer_d   = timer_q;
    half_d    = half_q;
    pins_d    = pins_q;
    unique case (mode_i)
      ModeMsTick: begin
        elapsed_d = el_inc;
        unique case (phase_q)
          PhReset: begin
            if (el_inc < cfg_i.reset_low_ms) begin
              pins_d.rst = 1'b0;
            end else begin
              pins_d.rst = 1'b1;
              pins_d.sel = 1'b1;
              phase_d    = PhSelect;
              elapsed_d  = '0;
            end
          end
          PhSelect: begin
            if (el_inc > cfg_i.select_high_ms || el_inc == MsMax) begin
              pins_d.sel = 1'b0;
              phase_d    = PhSettle;
              elapsed_d  = '0;
            end
          end
          PhSettle: begin
            if (el_inc > cfg_i.settle_ms || el_inc == MsMax) begin
              phase_d    = PhShift;
              elapsed_d  = '0;
              bits_d     = '0;
              pins_d.clk = 1'b0;
              pins_d.dat = shift_q[0];
              shift_d    = shift_q >> 1;
              timer_d    = '0;
              half_d     = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ModeUsTick: begin
        if (phase_q == PhShift) begin
          timer_d = tm_inc;
          if (!half_q) begin
            if (tm_inc >= cfg_i.bit_low_us) begin
              pins_d.clk = 1'b1;
              half_d     = 1'b1;
              timer_d    = '0;
            end
          end else if (tm_inc >= cfg_i.bit_high_us) begin
            if (bits_inc >= BitsTotal) begin
              pins_d.sel = 1'b1;
              phase_d    = PhIdle;
              bits_d     = '0;
              timer_d    = '0;
              half_d     = 1'b0;
            end else begin
              bits_d     = bits_inc[CntW-1:0];
              pins_d.clk = 1'b0;
              pins_d.dat = shift_q[0];
              shift_d    = shift_q >> 1;
              timer_d    = '0;
              half_d     = 1'b0;
            end
          end
        end
      end
      ModeSound, ModeAlarm: begin
        if (req_en) begin
          shift_d   = track_i;
          elapsed_d = '0;
          if (phase_q == PhIdle) begin
            phase_d    = PhReset;
            pins_d.rst = 1'b0;
          end else if (phase_q == PhShift) begin
            bits_d     = '0;
            pins_d.clk = 1'b0;
            pins_d.dat = track_i[0];
            shift_d    = track_i >> 1;
            timer_d    = '0;
            half_d     = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.pins = pins_d;
  assign res_o.busy = (phase_d != PhIdle);

  a_half_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> phase_q == PhShift)
    else $error("clock high half outside shift phase");

  a_reset_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhReset |-> !pins_q.rst)
    else $error("reset line high during reset phase");

  a_settle_selected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSettle |-> !pins_q.sel)
    else $error("select line high during settle phase");

  a_stray_us: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && mode_i == ModeUsTick && phase_q != PhShift) |=>
      ($stable(pins_q) && $stable(phase_q)))
    else $error("stray microsecond tick changed state");

endmodule

>>> rtl/sound_module_command_sequencer.sv
// Top level of the three-wire sound module command sequencer.
//
// Channels: cmd_i takes one command per transaction (mode 0 millisecond
// tick, 1 microsecond tick, 2 sound request, 3 alarm request, with track).
// pin_o returns exactly one transaction per command: the reset, select,
// clock and data pin levels after that command, and the busy flag.
// cfg_i writes the timing and enable registers; it is always ready and
// must only be used while no command is in flight.
// Accepted commands pass the command register, then the result register.
// Throughput: one command per cycle while pin_o is not stalled, set by the
// state update between the command register and the result register.
// Stall: while pin_o is stalled the result is held; one more command is
// taken into the command register, then cmd_i.ready drops.
// Reset: sequencer idle, pins reset high, select high, clock high, data
// low; registers take their default timing and both enables set.
module sound_module_command_sequencer
  import smcs_pkg::*;
#(
  parameter int unsigned TRACK_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  smcs_cmd_if.sink   cmd_i,
  smcs_pin_if.source pin_o,
  smcs_cfg_if.sink   cfg_i
);

  logic              in_valid_q, in_valid_d;
  mode_e             mode_q;
  logic [TrackW-1:0] track_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  result_t           res;
  cfg_t              cfg_q;
  logic              advance;
  logic              accept;

  assign advance     = in_valid_q && (!out_valid_q || pin_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (pin_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_e'(cmd_i.mode);
      track_q <= cmd_i.track;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgResetLowMs:   cfg_q.reset_low_ms   <= cfg_i.data;
        CfgSelectHighMs: cfg_q.select_high_ms <= cfg_i.data;
        CfgSettleMs:     cfg_q.settle_ms      <= cfg_i.data;
        CfgBitLowUs:     cfg_q.bit_low_us     <= cfg_i.data[UsW-1:0];
        CfgBitHighUs:    cfg_q.bit_high_us    <= cfg_i.data[UsW-1:0];
        CfgSoundEnable:  cfg_q.sound_enable   <= cfg_i.data[0];
        CfgAlarmEnable:  cfg_q.alarm_enable   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  smcs_core #(
    .TRACK_BITS(TRACK_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .mode_i  (mode_q),
    .track_i (track_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  assign pin_o.valid       = out_valid_q;
  assign pin_o.reset_line  = out_q.pins.rst;
  assign pin_o.select_line = out_q.pins.sel;
  assign pin_o.clock_line  = out_q.pins.clk;
  assign pin_o.data_line   = out_q.pins.dat;
  assign pin_o.busy_res    = out_q.busy;

endmodule

>>> verif/tb_sound_module_command_sequencer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sound module command sequencer.
module tb_sound_module_command_sequencer;
  import smcs_pkg::*;

  localparam int unsigned TrackBits   = 8;
  localparam int          NumItems    = 450;
  localparam int          DrainCycles = 4;
  localparam int          StallLimit  = 2000;

  typedef struct {
    mode_e             mode;
    logic [TrackW-1:0] track;
  } cmd_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  smcs_cmd_if cmd_if();
  smcs_pin_if pin_if();
  smcs_cfg_if cfg_if();

  sound_module_command_sequencer #(
    .TRACK_BITS(TrackBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .pin_o (pin_if),
    .cfg_i (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cmd_item_t cmd_pending_q[$];
  cmd_item_t cmd_next;
  result_t   pin_expect_q[$];
  result_t   pin_want;
  cfg_t      plan;
  int        cmd_count;
  int        fail_count;
  int        cmd_gap;
  logic      cmd_idle;
  int        pin_stall;
  int        pin_wait;
  logic      pin_idle;
  int        idle_cycles;

  // Sequencer shadow state
  cfg_t              reg_file;
  phase_e            seq_phase;
  logic [MsW-1:0]    ms_count;
  logic [TrackW-1:0] shift_bits;
  int                bits_done;
  logic [UsW-1:0]    us_count;
  logic              clk_high_half;
  pins_t             pin_state;

  function automatic void present_next_bit();
    pin_state.clk = 1'b0;
    pin_state.dat = shift_bits[0];
    shift_bits    = shift_bits >> 1;
    us_count      = '0;
    clk_high_half = 1'b0;
  endfunction

  function automatic void load_register(cfg_idx_e idx, logic [CfgDatW-1:0] val);
    case (idx)
      CfgResetLowMs:   reg_file.reset_low_ms   = val;
      CfgSelectHighMs: reg_file.select_high_ms = val;
      CfgSettleMs:     reg_file.settle_ms      = val;
      CfgBitLowUs:     reg_file.bit_low_us     = val[UsW-1:0];
      CfgBitHighUs:    reg_file.bit_high_us    = val[UsW-1:0];
      CfgSoundEnable:  reg_file.sound_enable   = val[0];
      CfgAlarmEnable:  reg_file.alarm_enable   = val[0];
      default: ;
    endcase
  endfunction

  function automatic void start_play(logic [TrackW-1:0] trk);
    shift_bits = trk;
    ms_count   = '0;
    if (seq_phase == PhIdle) begin
      seq_phase     = PhReset;
      pin_state.rst = 1'b0;
    end else if (seq_phase == PhShift) begin
      bits_done = 0;
      present_next_bit();
    end
  endfunction

  function automatic void advance_sequencer(mode_e op, logic [TrackW-1:0] trk);
    case (op)
      ModeMsTick: begin
        if (ms_count != MsMax) ms_count = ms_count + 1'b1;
        case (seq_phase)
          PhReset: begin
            if (ms_count < reg_file.reset_low_ms) begin
              pin_state.rst = 1'b0;
            end else begin
              pin_state.rst = 1'b1;
              pin_state.sel = 1'b1;
              seq_phase     = PhSelect;
              ms_count      = '0;
            end
          end
          PhSelect: begin
            if (ms_count > reg_file.select_high_ms || ms_count == MsMax) begin
              pin_state.sel = 1'b0;
              seq_phase     = PhSettle;
              ms_count      = '0;
            end
          end
          PhSettle: begin
            if (ms_count > reg_file.settle_ms || ms_count == MsMax) begin
              seq_phase = PhShift;
              ms_count  = '0;
              bits_done = 0;
              present_next_bit();
            end
          end
          default: ;
        endcase
      end
      ModeUsTick: begin
        if (seq_phase == PhShift) begin
          us_count = us_count + 1'b1;
          if (!clk_high_half) begin
            if (us_count >= reg_file.bit_low_us) begin
              pin_state.clk = 1'b1;
              clk_high_half = 1'b1;
              us_count      = '0;
            end
          end else if (us_count >= reg_file.bit_high_us) begin
            if (bits_done + 1 >= TrackBits) begin
              pin_state.sel = 1'b1;
              seq_phase     = PhIdle;
              bits_done     = 0;
              us_count      = '0;
              clk_high_half = 1'b0;
            end else begin
              bits_done = bits_done + 1;
              present_next_bit();
            end
          end
        end
      end
      ModeSound: if (reg_file.sound_enable) start_play(trk);
      ModeAlarm: if (reg_file.alarm_enable) start_play(trk);
      default: ;
    endcase
    pin_expect_q.push_back('{pins: pin_state, busy: seq_phase != PhIdle});
  endfunction

  function automatic void check_pin(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      fail_count++;
    end
  endfunction

  // Command driver and sequencer shadow update
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid  <= 1'b0;
      cmd_if.mode   <= ModeMsTick;
      cmd_if.track  <= '0;
      cmd_gap       <= 0;
      cmd_idle      <= 1'b0;
      reg_file      = CfgReset;
      seq_phase     = PhIdle;
      ms_count      = '0;
      shift_bits    = '0;
      bits_done     = 0;
      us_count      = '0;
      clk_high_half = 1'b0;
      pin_state     = PinsReset;
    end else begin
      if (cmd_if.valid && cmd_if.ready) advance_sequencer(mode_e'(cmd_if.mode), cmd_if.track);
      if (cfg_if.valid && cfg_if.ready) load_register(cfg_idx_e'(cfg_if.index), cfg_if.data);
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_gap > 0) begin
          cmd_if.valid <= 1'b0;
          cmd_gap      <= cmd_gap - 1;
        end else if (cmd_pending_q.size() != 0) begin
          cmd_next     = cmd_pending_q.pop_front();
          cmd_if.valid <= 1'b1;
          cmd_if.mode  <= cmd_next.mode;
          cmd_if.track <= cmd_next.track;
          cmd_gap      <= cmd_idle ? int'($urandom_range(0, 14)) : 0;
          if ($urandom_range(0, 15) == 0) cmd_idle <= !cmd_idle;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Pin monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_if.ready <= 1'b0;
      pin_stall    <= 0;
      pin_idle     <= 1'b0;
    end else begin
      pin_wait = pin_stall;
      if (pin_if.valid && pin_if.ready) begin
        if (pin_expect_q.size() == 0) begin
          $error("pin transaction with no command outstanding");
          fail_count++;
        end else begin
          pin_want = pin_expect_q.pop_front();
          check_pin("reset_line", pin_want.pins.rst, pin_if.reset_line);
          check_pin("select_line", pin_want.pins.sel, pin_if.select_line);
          check_pin("clock_line", pin_want.pins.clk, pin_if.clock_line);
          check_pin("data_line", pin_want.pins.dat, pin_if.data_line);
          check_pin("busy_res", pin_want.busy, pin_if.busy_res);
        end
        pin_wait = pin_idle ? int'($urandom_range(0, 14)) : 0;
        if ($urandom_range(0, 15) == 0) pin_idle <= !pin_idle;
      end
      if (pin_wait > 0) begin
        pin_if.ready <= 1'b0;
        pin_stall    <= pin_wait - 1;
      end else begin
        pin_if.ready <= 1'b1;
        pin_stall    <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (pin_if.valid && pin_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void add_cmd(mode_e m, logic [TrackW-1:0] trk);
    cmd_pending_q.push_back('{mode: m, track: trk});
    cmd_count++;
  endfunction

  task automatic wait_drained();
    while (cmd_pending_q.size() != 0 || cmd_if.valid || pin_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDatW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic program_regs(cfg_t c);
    wait_drained();
    plan = c;
    write_reg(CfgResetLowMs, c.reset_low_ms);
    write_reg(CfgSelectHighMs, c.select_high_ms);
    write_reg(CfgSettleMs, c.settle_ms);
    write_reg(CfgBitLowUs, {2'($urandom), c.bit_low_us});
    write_reg(CfgBitHighUs, {2'($urandom), c.bit_high_us});
    write_reg(CfgSoundEnable, {7'($urandom), c.sound_enable});
    write_reg(CfgAlarmEnable, {7'($urandom), c.alarm_enable});
    cfg_if.valid <= 1'b0;
  endtask

  // Queue one play request and enough ticks to finish it if noise_pct is zero.
  task automatic queue_play(int noise_pct);
    mode_e req;
    int    n_ms;
    int    n_us;
    if (plan.sound_enable && plan.alarm_enable) req = $urandom_range(0, 1) ? ModeSound : ModeAlarm;
    else if (plan.sound_enable) req = ModeSound;
    else req = ModeAlarm;
    add_cmd(req, TrackW'($urandom));
    n_ms = (plan.reset_low_ms == 0 ? 1 : int'(plan.reset_low_ms))
         + (plan.select_high_ms == MsMax ? 255 : int'(plan.select_high_ms) + 1)
         + (plan.settle_ms == MsMax ? 255 : int'(plan.settle_ms) + 1)
         + int'($urandom_range(0, 2));
    n_us = TrackBits * ((plan.bit_low_us == 0 ? 1 : int'(plan.bit_low_us))
         + (plan.bit_high_us == 0 ? 1 : int'(plan.bit_high_us)))
         + int'($urandom_range(0, 2));
    for (int i = 0; i < n_ms + n_us; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        add_cmd(mode_e'($urandom_range(0, 3)), TrackW'($urandom));
      else
        add_cmd(i < n_ms ? ModeMsTick : ModeUsTick, TrackW'($urandom));
    end
  endtask

  initial begin
    cfg_t c;
    rst_ni       = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.mode  = ModeMsTick;
    cmd_if.track = '0;
    pin_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CfgResetLowMs;
    cfg_if.data  = '0;
    fail_count   = 0;
    cmd_count    = 0;
    idle_cycles  = 0;
    plan         = CfgReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero timing: each wait ends on its first tick
    program_regs('{reset_low_ms: 8'd0, select_high_ms: 8'd0, settle_ms: 8'd0,
                   bit_low_us: 6'd0, bit_high_us: 6'd0, sound_enable: 1'b1,
                   alarm_enable: 1'b1});
    add_cmd(ModeUsTick, 8'h00);
    add_cmd(ModeAlarm, 8'hFF);
    repeat (3) add_cmd(ModeMsTick, 8'h5A);
    repeat (2) add_cmd(ModeUsTick, 8'hA5);
    add_cmd(ModeSound, 8'h80);
    repeat (16) add_cmd(ModeUsTick, 8'hFF);
    add_cmd(ModeMsTick, 8'h00);

    // Saturate the millisecond counter in the select wait
    program_regs('{reset_low_ms: 8'd1, select_high_ms: 8'd255, settle_ms: 8'd0,
                   bit_low_us: 6'd1, bit_high_us: 6'd1, sound_enable: 1'b0,
                   alarm_enable: 1'b1});
    add_cmd(ModeSound, TrackW'($urandom));
    queue_play(0);

    // Longest bit times
    program_regs('{reset_low_ms: 8'd0, select_high_ms: 8'd0, settle_ms: 8'd0,
                   bit_low_us: 6'd63, bit_high_us: 6'd63, sound_enable: 1'b1,
                   alarm_enable: 1'b0});
    add_cmd(ModeAlarm, TrackW'($urandom));
    add_cmd(ModeSound, TrackW'($urandom));
    repeat (3) add_cmd(ModeMsTick, TrackW'($urandom));
    repeat (70) add_cmd(ModeUsTick, TrackW'($urandom));

    program_regs('{reset_low_ms: 8'd255, select_high_ms: 8'd254, settle_ms: 8'd255,
                   bit_low_us: 6'd0, bit_high_us: 6'd63, sound_enable: 1'b1,
                   alarm_enable: 1'b1});
    repeat (20) add_cmd(mode_e'($urandom_range(0, 3)), TrackW'($urandom));

    program_regs('{reset_low_ms: 8'd255, select_high_ms: 8'd0, settle_ms: 8'd254,
                   bit_low_us: 6'd63, bit_high_us: 6'd0, sound_enable: 1'b0,
                   alarm_enable: 1'b0});
    repeat (12) add_cmd(mode_e'($urandom_range(0, 3)), TrackW'($urandom));

    while (cmd_count < NumItems) begin
      c.reset_low_ms   = 8'($urandom_range(0, 4));
      c.select_high_ms = 8'($urandom_range(0, 4));
      c.settle_ms      = 8'($urandom_range(0, 4));
      c.bit_low_us     = 6'($urandom_range(0, 3));
      c.bit_high_us    = 6'($urandom_range(0, 3));
      c.sound_enable   = $urandom_range(0, 4) != 0;
      c.alarm_enable   = $urandom_range(0, 4) != 0;
      program_regs(c);
      repeat ($urandom_range(1, 3)) queue_play($urandom_range(0, 12));
      repeat ($urandom_range(0, 6)) add_cmd(mode_e'($urandom_range(0, 3)), TrackW'($urandom));
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pin_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sound_module_command_sequencer.f
rtl/smcs_pkg.sv
rtl/smcs_cmd_if.sv
rtl/smcs_pin_if.sv
rtl/smcs_cfg_if.sv
rtl/smcs_core.sv
rtl/sound_module_command_sequencer.sv
verif/tb_sound_module_command_sequencer.sv
